// ===== hw/rtl/pfau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfau_pkg: shared types and constants for the prime field arithmetic unit
// Holds the command codes, the controller-to-datapath command struct and the
// status struct that travels back.
// ----------------------------------------------------------------------------
package pfau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam logic [31:0] RESET_MODULUS = 32'hFFF0_0001;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_POW = 3'd3;
   localparam logic [2:0] CMD_INV = 3'd4;
   localparam logic [2:0] CMD_DIV = 3'd5;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_LOAD    = 4'd1,   // latch operands, start reduction of a
      OP_RED_B   = 4'd2,   // start reduction of b
      OP_ADDSUB  = 4'd3,   // add or subtract reduced operands
      OP_POWINIT = 4'd4,   // acc = 1 mod p, base/exponent set up
      OP_MULACC  = 4'd5,   // start acc * base
      OP_SQR     = 4'd6,   // start base * base
      OP_SHIFT   = 4'd7,   // exponent shift, count step
      OP_DIVSET  = 4'd8,   // base = acc (inverse of b), acc stays
      OP_ZERO    = 4'd9,   // result forced to zero
      OP_MULAB   = 4'd10,  // start a * b
      OP_LAND    = 4'd11   // result = accumulator
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      inv_b;     // power setup: invert b instead of a
      logic      exp_p2;    // power setup: exponent is p-2
   } dp_cmd_type;

   typedef struct packed {
      logic busy;          // reduction unit working
      logic exp_bit;       // current exponent bit
      logic last_bit;      // final exponent bit reached
      logic p_small;       // modulus below two
   } dp_status_type;

endpackage

// ===== hw/rtl/pfau_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfau_datapath: operand registers and a shared bit-serial reduction unit
// Every reduction (operand mod p, product mod p) goes through one restoring
// shift-subtract unit that takes one remainder bit per cycle.
// ----------------------------------------------------------------------------
module pfau_datapath
   import pfau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [2:0]           command,
   input  logic [WORD_BITS-1:0] modulus,
   input  logic [WORD_BITS-1:0] operand_a,
   input  logic [WORD_BITS-1:0] operand_b,
   output dp_status_type        status,
   output logic [WORD_BITS-1:0] result
);

   localparam int W  = WORD_BITS;
   localparam int DW = 2 * WORD_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam int EW = $clog2(W + 1);

   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] acc_ff, acc_in, base_ff, base_in, exp_ff, exp_in;
   logic [EW-1:0] ecnt_ff, ecnt_in;
   logic [W-1:0] res_ff, res_in;
   // reduction unit: dividend shifted out from top, remainder built up
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [W:0]    rem_ff, rem_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic [1:0]    dst_ff, dst_in;   // 0 a, 1 b, 2 acc, 3 base
   logic [DW-1:0] prod;
   logic [W-1:0]  mul_x;
   logic [W+1:0]  rshift, rdiff;
   logic [W:0]    sum;
   logic [W-1:0]  rem_w, one_mod;
   logic          done_pulse;
   logic [W-1:0]  fin;

   localparam logic [1:0] DST_A = 2'd0, DST_B = 2'd1, DST_ACC = 2'd2, DST_BASE = 2'd3;

   // product operand select, one shared multiplier feeds the reducer
   always_comb begin
      case (cmd.op)
         OP_MULACC: mul_x = acc_ff;
         OP_SQR:    mul_x = base_ff;
         OP_MULAB:  mul_x = a_ff;
         default:   mul_x = '0;
      endcase
   end
   assign prod = DW'(mul_x) * DW'(base_ff);

   assign rshift  = {rem_ff, dvd_ff[DW-1]};
   assign rdiff   = rshift - {2'b00, modulus};
   assign rem_w   = rem_ff[W-1:0];
   assign sum     = {1'b0, a_ff} + {1'b0, rem_w};
   assign one_mod = (modulus == W'(1)) ? '0 : W'(1);

   // last reduction step: final remainder, landed in acc or base for products
   assign done_pulse = (rcnt_ff == CW'(1));
   assign fin = rdiff[W+1] ? rshift[W-1:0] : rdiff[W-1:0];

   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; base_in = base_ff;
      exp_in = exp_ff; ecnt_in = ecnt_ff; res_in = res_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; rcnt_in = rcnt_ff; dst_in = dst_ff;

      // advance reduction one bit
      if (rcnt_ff != '0) begin
         dvd_in  = {dvd_ff[DW-2:0], 1'b0};
         rem_in  = rdiff[W+1] ? rshift[W:0] : rdiff[W:0];
         rcnt_in = rcnt_ff - CW'(1);
      end

      // capture a finished product
      if (done_pulse && dst_ff == DST_ACC)  acc_in  = fin;
      if (done_pulse && dst_ff == DST_BASE) base_in = fin;

      case (cmd.op)
         OP_LOAD: begin
            b_in    = operand_b;
            exp_in  = operand_b;
            dvd_in  = {operand_a, {W{1'b0}}};
            rem_in  = '0;
            rcnt_in = CW'(W);
            dst_in  = DST_A;
         end
         OP_RED_B: begin
            a_in    = rem_w;
            dvd_in  = {b_ff, {W{1'b0}}};
            rem_in  = '0;
            rcnt_in = CW'(W);
            dst_in  = DST_B;
         end
         OP_ADDSUB: begin
            b_in = rem_w;
            if (command == CMD_ADD) begin
               res_in = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : sum[W-1:0];
            end else begin
               res_in = (a_ff >= rem_w) ? a_ff - rem_w : a_ff + (modulus - rem_w);
            end
         end
         OP_POWINIT: begin
            if (dst_ff == DST_B) b_in = rem_w;
            acc_in  = one_mod;
            base_in = cmd.inv_b ? rem_w : a_ff;
            if (cmd.exp_p2) exp_in = modulus - W'(2);
            ecnt_in = '0;
         end
         OP_MULACC, OP_SQR, OP_MULAB: begin
            dvd_in  = prod;
            rem_in  = '0;
            rcnt_in = CW'(DW);
            dst_in  = (cmd.op == OP_SQR) ? DST_BASE : DST_ACC;
         end
         OP_SHIFT: begin
            exp_in  = exp_ff >> 1;
            ecnt_in = ecnt_ff + EW'(1);
         end
         OP_DIVSET: begin
            base_in = acc_ff;
         end
         OP_ZERO: res_in = '0;
         OP_LAND: res_in = acc_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; exp_ff <= exp_in; res_ff <= res_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; dst_ff <= dst_in;
      acc_ff <= acc_in; base_ff <= base_in;
      if (reset) begin
         rcnt_ff <= '0;
         ecnt_ff <= '0;
      end else begin
         rcnt_ff <= rcnt_in;
         ecnt_ff <= ecnt_in;
      end
   end

   assign status.busy     = (rcnt_ff != '0);
   assign status.exp_bit  = exp_ff[0];
   assign status.last_bit = (ecnt_ff == EW'(W - 1));
   assign status.p_small  = (modulus < W'(2));
   assign result          = res_ff;

endmodule

// ===== hw/rtl/pfau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfau_ctrl: sequencer for the prime field arithmetic unit
// Steps the datapath through reduction, then add/sub, one product or
// square-and-multiply, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module pfau_ctrl
   import pfau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    command,
   output logic [2:0]    cmd_hold,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_REDA  = 12'b000000000010,
      S_REDB  = 12'b000000000100,
      S_SEL   = 12'b000000001000,
      S_MUL   = 12'b000000010000,
      S_WMUL  = 12'b000000100000,
      S_SQR   = 12'b000001000000,
      S_WSQR  = 12'b000010000000,
      S_NEXT  = 12'b000100000000,
      S_DIV   = 12'b001000000000,
      S_WDIV  = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   state_type st_ff, st_in;
   logic [2:0] c_ff, c_in;

   assign cmd_hold  = c_ff;
   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_DONE);

   always_comb begin
      st_in = st_ff; c_in = c_ff;
      cmd = '{op: OP_NONE, inv_b: 1'b0, exp_p2: 1'b0};
      case (st_ff)
         S_IDLE: if (req_valid) begin
            c_in = command;
            cmd.op = OP_LOAD; st_in = S_REDA;
         end
         S_REDA: if (!status.busy) begin
            cmd.op = OP_RED_B; st_in = S_REDB;
         end
         S_REDB: if (!status.busy) begin
            if (status.p_small || c_ff > CMD_DIV) begin
               cmd.op = OP_ZERO; st_in = S_DONE;
            end else if (c_ff == CMD_ADD || c_ff == CMD_SUB) begin
               cmd.op = OP_ADDSUB; st_in = S_DONE;
            end else if (c_ff == CMD_MUL) begin
               cmd.op = OP_POWINIT; cmd.inv_b = 1'b1; st_in = S_DIV;
            end else begin
               cmd.op = OP_POWINIT;
               cmd.inv_b  = (c_ff == CMD_DIV);
               cmd.exp_p2 = (c_ff != CMD_POW);
               st_in = S_SEL;
            end
         end
         S_SEL: st_in = status.exp_bit ? S_MUL : S_SQR;
         S_MUL: begin cmd.op = OP_MULACC; st_in = S_WMUL; end
         S_WMUL: if (!status.busy) st_in = S_SQR;
         S_SQR: begin cmd.op = OP_SQR; st_in = S_WSQR; end
         S_WSQR: if (!status.busy) st_in = S_NEXT;
         S_NEXT: begin
            if (status.last_bit) begin
               if (c_ff == CMD_DIV) begin
                  cmd.op = OP_DIVSET; st_in = S_DIV;
               end else begin
                  // copy accumulator into result on entry to done
                  cmd.op = OP_LAND; st_in = S_DONE;
               end
            end else begin
               cmd.op = OP_SHIFT; st_in = S_SEL;
            end
         end
         S_DIV: begin cmd.op = OP_MULAB; st_in = S_WDIV; end
         S_WDIV: if (!status.busy) begin cmd.op = OP_LAND; st_in = S_DONE; end
         S_DONE: if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== hw/rtl/prime_field_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_arith_unit: modular arithmetic over GF(p), p programmable
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   command, operand_a, operand_b
//   rsp      out        rsp_valid / rsp_stall   result
//   csr      in         APB write/read          modulus at address 0
//
// One item at a time. Each operand reduction and each modular product runs
// in a one-bit-per-cycle remainder unit. Add/sub reduce both operands, then
// add or subtract; multiply forms one product of the reduced operands.
// Power and inverse run square-and-multiply over the exponent bits, with a
// product for a set bit and a square for every bit; divide adds one product.
// The next item is accepted only once the result has left.
// Reset is synchronous and returns the modulus to 0xFFF00001.
// req_stall is high while an item is in flight; result holds under rsp_stall.
// ----------------------------------------------------------------------------
module prime_field_arith_unit
   import pfau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [WORD_BITS-1:0] mod_ff, res;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    cmd_hold;

   // modulus register
   always_ff @(posedge clock) begin
      if (reset) mod_ff <= RESET_MODULUS[WORD_BITS-1:0];
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         mod_ff <= csr_pwdata[WORD_BITS-1:0];
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(mod_ff) : 32'd0;

   pfau_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .command(req_command),
      .cmd_hold, .rsp_valid, .rsp_stall, .cmd, .status
   );

   pfau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock, .reset, .cmd, .command(cmd_hold), .modulus(mod_ff),
      .operand_a(req_operand_a[WORD_BITS-1:0]),
      .operand_b(req_operand_b[WORD_BITS-1:0]),
      .status, .result(res)
   );

   assign rsp_result = 32'(res);

endmodule
